>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers for the evaluator checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define PFE_ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("pfe assertion failed");

// assertion on the default clk / rst_n pair
`define PFE_ASSERT(lbl, prop) `PFE_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

>>> rtl/pfe_pkg.sv
// ---------------------------------------------------------------------------
// pfe_pkg
// types, codes and helpers of the postfix expression evaluator
// ---------------------------------------------------------------------------
package pfe_pkg;

  localparam int DEF_STACK_DEPTH     = 64;
  localparam int DEF_FRAC_BITS       = 16;
  localparam int DEF_POWER_STEPS_MAX = 255;

  // ascii codes
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_STAR  = 8'h2A;
  localparam logic [7:0] ASCII_SLASH = 8'h2F;
  localparam logic [7:0] ASCII_CARET = 8'h5E;
  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_POW} alu_op_t;

  typedef enum logic [1:0] {CELL_HOLD, CELL_FROM_UP, CELL_FROM_DOWN} cell_op_t;

  typedef enum logic [1:0] {T_IDLE, T_ALU, T_EMIT} top_state_t;

  typedef enum logic [2:0] {A_IDLE, A_MULP, A_MULS, A_DIV, A_DFIN, A_DONE} alu_state_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic div0;
  } alu_stat_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_res_t;

  // magnitude of a signed 32-bit word, min maps to 2^31
  function automatic logic [31:0] mag32(logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // apply sign to a magnitude and clamp to the signed 32-bit range
  function automatic sat_res_t sat_mag(logic [63:0] m, logic neg);
    sat_res_t r;
    if (neg) begin
      if (m > 64'h8000_0000) begin
        r.val = Q_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = ~m[31:0] + 32'd1;
        r.sat = 1'b0;
      end
    end else begin
      if (m > 64'h7FFF_FFFF) begin
        r.val = Q_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = m[31:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/postfix_expression_evaluator.sv
// ---------------------------------------------------------------------------
// postfix_expression_evaluator
// rpn evaluator over a shifting operand stack, signed fixed point values
// ---------------------------------------------------------------------------
// One ASCII character arrives per input beat. Digits push their value
// (Q-format, FRAC_BITS fraction bits), + - * / ^ pop b then a and push
// a op b, anything else is skipped. On the beat with in_tlast set the
// character is processed, then one output beat carries the top of stack
// and a status (ok, underflow, stack overflow, divide by zero, saturated,
// empty), and the stack is cleared. The stack is a row of STACK_DEPTH cells
// with the top in cell 0; a push shifts every cell down one place, an
// operator shifts up one place and drops the result into cell 0. Digits
// and skipped characters are taken directly; + and - go straight through
// the operator unit, * through the multiplier, / through the restoring
// divider (one quotient bit a cycle), ^ through min(ceil(b),
// POWER_STEPS_MAX) multiplies on the shared multiplier; a final beat also
// loads the output register. Items are handled one at a time; the output
// register lets the next expression start while the result still waits on out_tready.
// ---------------------------------------------------------------------------
module postfix_expression_evaluator
  import pfe_pkg::*;
#(
  parameter int STACK_DEPTH     = DEF_STACK_DEPTH,
  parameter int FRAC_BITS       = DEF_FRAC_BITS,
  parameter int POWER_STEPS_MAX = DEF_POWER_STEPS_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] symbol
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);

  top_state_t   state_r, state_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [2:0]   err_r, err_nxt;
  logic         last_r, last_nxt;
  logic         ovalid_r, ovalid_nxt;
  logic [31:0]  oval_r, oval_nxt;
  logic [2:0]   ostat_r, ostat_nxt;

  // stack row
  logic [31:0]  cell_q [STACK_DEPTH];
  cell_op_t     cell_op [STACK_DEPTH];
  logic         do_push;
  logic         do_reduce;
  logic [31:0]  top_in;

  // operator unit
  logic         alu_start;
  alu_op_t      alu_op;
  logic [31:0]  alu_res;
  alu_stat_t    alu_stat;

  // decode of the incoming symbol
  logic         accept;
  logic         is_digit;
  logic         is_op;
  logic [63:0]  dig_mag;
  sat_res_t     dig;
  logic         full;
  logic [2:0]   cand;

  assign accept   = in_tvalid && in_tready;
  assign is_digit = in_tdata inside {[ASCII_0:ASCII_9]};
  assign dig_mag  = 64'(in_tdata - ASCII_0) << FRAC_BITS;
  assign dig      = sat_mag(dig_mag, 1'b0);
  assign full     = (sp_r == SPW'(STACK_DEPTH));

  always_comb begin
    is_op  = 1'b1;
    alu_op = ALU_ADD;
    case (in_tdata)
      ASCII_PLUS:  alu_op = ALU_ADD;
      ASCII_MINUS: alu_op = ALU_SUB;
      ASCII_STAR:  alu_op = ALU_MUL;
      ASCII_SLASH: alu_op = ALU_DIV;
      ASCII_CARET: alu_op = ALU_POW;
      default:     is_op  = 1'b0;
    endcase
  end

  // control: next state, stack pointer, error latch, output register
  always_comb begin
    state_nxt  = state_r;
    sp_nxt     = sp_r;
    err_nxt    = err_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r;
    oval_nxt   = oval_r;
    ostat_nxt  = ostat_r;
    do_push    = 1'b0;
    do_reduce  = 1'b0;
    alu_start  = 1'b0;
    in_tready  = 1'b0;
    cand       = ST_OK;

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      T_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          last_nxt  = in_tlast;
          state_nxt = in_tlast ? T_EMIT : T_IDLE;
          if (is_digit) begin
            // clamp error is noted before the overflow check
            if (dig.sat) cand = ST_SAT;
            else if (full) cand = ST_OVER;
            if (!full) begin
              do_push = 1'b1;
              sp_nxt  = sp_r + SPW'(1);
            end
          end else if (is_op) begin
            if (sp_r < SPW'(2)) begin
              cand = ST_UNDER;
            end else begin
              alu_start = 1'b1;
              state_nxt = T_ALU;
            end
          end
          if (err_r == ST_OK) err_nxt = cand;
        end
      end
      T_ALU: begin
        if (alu_stat.done) begin
          do_reduce = 1'b1;
          sp_nxt    = sp_r - SPW'(1);
          if (alu_stat.div0) cand = ST_DIV0;
          else if (alu_stat.sat) cand = ST_SAT;
          if (err_r == ST_OK) err_nxt = cand;
          state_nxt = last_r ? T_EMIT : T_IDLE;
        end
      end
      T_EMIT: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          oval_nxt   = (sp_r != '0) ? cell_q[0] : 32'd0;
          if (err_r != ST_OK) ostat_nxt = err_r;
          else if (sp_r == '0) ostat_nxt = ST_EMPTY;
          else ostat_nxt = ST_OK;
          sp_nxt     = '0;
          err_nxt    = ST_OK;
          state_nxt  = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      sp_r     <= '0;
      err_r    <= ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    oval_r  <= oval_nxt;
    ostat_r <= ostat_nxt;
  end

  // cell 0 takes the pushed digit or the operator result
  assign top_in = do_reduce ? alu_res : dig.val;

  genvar gi;
  generate
    for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_top
        assign cell_op[gi] = (do_push || do_reduce) ? CELL_FROM_UP : CELL_HOLD;
        pfe_cell u_cell (
          .clk     (clk),
          .op      (cell_op[gi]),
          .up_in   (top_in),
          .down_in (cell_q[gi + 1]),
          .q       (cell_q[gi])
        );
      end else begin : g_body
        assign cell_op[gi] = do_push ? CELL_FROM_UP :
                             do_reduce ? CELL_FROM_DOWN : CELL_HOLD;
        pfe_cell u_cell (
          .clk     (clk),
          .op      (cell_op[gi]),
          .up_in   (cell_q[gi - 1]),
          .down_in ((gi == STACK_DEPTH - 1) ? cell_q[gi] : cell_q[(gi + 1) % STACK_DEPTH]),
          .q       (cell_q[gi])
        );
      end
    end
  endgenerate

  // b is the top entry, a the one below it
  pfe_alu #(
    .FRAC_BITS       (FRAC_BITS),
    .POWER_STEPS_MAX (POWER_STEPS_MAX)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .op     (alu_op),
    .a      (cell_q[1]),
    .b      (cell_q[0]),
    .result (alu_res),
    .stat   (alu_stat)
  );

  assign out_tvalid = ovalid_r;
  assign out_tdata  = oval_r;
  assign out_tuser  = ostat_r;

endmodule

>>> rtl/pfe_cell.sv
// ---------------------------------------------------------------------------
// pfe_cell
// one operand stack entry; shifts toward or away from the top
// ---------------------------------------------------------------------------
module pfe_cell
  import pfe_pkg::*;
(
  input  logic        clk,
  input  cell_op_t    op,
  input  logic [31:0] up_in,    // neighbor nearer the top (or new value)
  input  logic [31:0] down_in,  // neighbor further from the top
  output logic [31:0] q
);

  logic [31:0] data_r;
  logic [31:0] data_nxt;

  always_comb begin
    case (op)
      CELL_FROM_UP:   data_nxt = up_in;
      CELL_FROM_DOWN: data_nxt = down_in;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

>>> rtl/pfe_alu.sv
// ---------------------------------------------------------------------------
// pfe_alu
// fixed point add, sub, multiply, restoring divide and repeated-multiply power
// ---------------------------------------------------------------------------
module pfe_alu
  import pfe_pkg::*;
#(
  parameter int FRAC_BITS       = DEF_FRAC_BITS,
  parameter int POWER_STEPS_MAX = DEF_POWER_STEPS_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  alu_op_t     op,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] result,
  output alu_stat_t   stat
);

  localparam int NQ   = 32 + FRAC_BITS;
  localparam int CW_P = $clog2(POWER_STEPS_MAX + 1);
  localparam int CW_D = $clog2(NQ + 1);
  localparam int CW   = (CW_P > CW_D) ? CW_P : CW_D;
  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [32:0] RND = 33'((64'd1 << FRAC_BITS) - 64'd1);

  alu_state_t      state_r, state_nxt;
  logic            pow_r, pow_nxt;
  logic            neg_r, neg_nxt;
  logic [31:0]     x_r, x_nxt;
  logic [31:0]     y_r, y_nxt;
  logic [63:0]     prod_r, prod_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [NQ-1:0]   dvd_r, dvd_nxt;
  logic [31:0]     res_r, res_nxt;
  logic            sat_r, sat_nxt;
  logic            div0_r, div0_nxt;

  logic [32:0]     sum;
  logic [32:0]     steps;
  logic [32:0]     rem2;
  sat_res_t        sr;

  always_comb begin
    state_nxt = state_r;
    pow_nxt   = pow_r;
    neg_nxt   = neg_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dvd_nxt   = dvd_r;
    res_nxt   = res_r;
    sat_nxt   = sat_r;
    div0_nxt  = div0_r;
    sum       = '0;
    steps     = (({1'b0, b} + RND) >> FRAC_BITS);
    rem2      = {rem_r, dvd_r[NQ-1]};
    sr        = sat_mag(prod_r >> FRAC_BITS, neg_r);

    case (state_r)
      A_IDLE: begin
        if (start) begin
          sat_nxt  = 1'b0;
          div0_nxt = 1'b0;
          case (op)
            ALU_ADD, ALU_SUB: begin
              sum = (op == ALU_ADD) ? ({a[31], a} + {b[31], b})
                                    : ({a[31], a} - {b[31], b});
              if (sum[32] != sum[31]) begin
                res_nxt = sum[32] ? Q_MIN : Q_MAX;
                sat_nxt = 1'b1;
              end else begin
                res_nxt = sum[31:0];
              end
              state_nxt = A_DONE;
            end
            ALU_MUL: begin
              x_nxt     = a;
              y_nxt     = b;
              pow_nxt   = 1'b0;
              state_nxt = A_MULP;
            end
            ALU_POW: begin
              if (b[31] || (b == 32'd0)) begin
                res_nxt   = ONE;
                state_nxt = A_DONE;
              end else begin
                x_nxt     = ONE;
                y_nxt     = a;
                pow_nxt   = 1'b1;
                cnt_nxt   = (steps > 33'(POWER_STEPS_MAX)) ? CW'(POWER_STEPS_MAX)
                                                          : CW'(steps);
                state_nxt = A_MULP;
              end
            end
            ALU_DIV: begin
              if (b == 32'd0) begin
                div0_nxt  = 1'b1;
                res_nxt   = a[31] ? Q_MIN : Q_MAX;
                state_nxt = A_DONE;
              end else begin
                dvd_nxt   = NQ'(mag32(a)) << FRAC_BITS;
                rem_nxt   = '0;
                y_nxt     = mag32(b);
                neg_nxt   = a[31] ^ b[31];
                cnt_nxt   = CW'(NQ);
                state_nxt = A_DIV;
              end
            end
            default: state_nxt = A_IDLE;
          endcase
        end
      end
      A_MULP: begin
        prod_nxt  = 64'(mag32(x_r)) * 64'(mag32(y_r));
        neg_nxt   = x_r[31] ^ y_r[31];
        state_nxt = A_MULS;
      end
      A_MULS: begin
        sat_nxt = sat_r | sr.sat;
        if (pow_r && (cnt_r > CW'(1))) begin
          x_nxt     = sr.val;
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = A_MULP;
        end else begin
          res_nxt   = sr.val;
          state_nxt = A_DONE;
        end
      end
      A_DIV: begin
        if (rem2 >= {1'b0, y_r}) begin
          rem_nxt = 32'(rem2 - {1'b0, y_r});
          dvd_nxt = {dvd_r[NQ-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[31:0];
          dvd_nxt = {dvd_r[NQ-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) state_nxt = A_DFIN;
      end
      A_DFIN: begin
        sr        = sat_mag(64'(dvd_r), neg_r);
        res_nxt   = sr.val;
        sat_nxt   = sr.sat;
        state_nxt = A_DONE;
      end
      A_DONE: state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pow_r  <= pow_nxt;
    neg_r  <= neg_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    prod_r <= prod_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    res_r  <= res_nxt;
    sat_r  <= sat_nxt;
    div0_r <= div0_nxt;
  end

  assign result    = res_r;
  assign stat.done = (state_r == A_DONE);
  assign stat.sat  = sat_r;
  assign stat.div0 = div0_r;

endmodule

>>> rtl/pfe_checker.sv
// ---------------------------------------------------------------------------
// pfe_checker
// port-level checks of the evaluator result channel
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pfe_checker
  import pfe_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser
);

  logic in_beat;
  logic in_digit;

  assign in_beat  = in_tvalid && in_tready;
  assign in_digit = (in_tdata >= ASCII_0) && (in_tdata <= ASCII_9);

  // status codes above empty never leave the block
  `PFE_ASSERT(a_status_range, out_tvalid |-> (out_tuser <= ST_EMPTY))

  // an empty stack reports a zero value
  `PFE_ASSERT(a_empty_zero, (out_tvalid && (out_tuser == ST_EMPTY)) |-> (out_tdata == 32'd0))

  // a stalled result beat holds
  `PFE_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))

  // the input closes after the final beat of an expression
  `PFE_ASSERT(a_last_closes, (in_beat && in_tlast) |=> !in_tready)

  // a digit in mid expression keeps the input open
  `PFE_ASSERT(a_digit_open, (in_beat && !in_tlast && in_digit) |=> in_tready)

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// postfix evaluator testbench
// drives postfix expressions character by character, predicts each final
// beat in fixed point and checks value and status of every output beat
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pfe_pkg::*;

  localparam int DEPTH     = DEF_STACK_DEPTH;
  localparam int FRAC      = DEF_FRAC_BITS;
  localparam int POW_MAX   = DEF_POWER_STEPS_MAX;
  localparam int STALL_MAX = 200000;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  status;
  } rpn_result_t;

  // fixed point evaluator with its own stack and the queue of pending answers
  class rpn_scoreboard;
    logic [31:0] stk[DEPTH];
    int          depth_used;
    logic [2:0]  err;
    rpn_result_t pending[$];
    int          fail_count;

    function void clear_expr();
      depth_used = 0;
      err = ST_OK;
    endfunction

    function void flag(logic [2:0] c);
      if (err == ST_OK) err = c;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) begin
        flag(ST_SAT);
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        flag(ST_SAT);
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint absval(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint signed_mag(longint m, bit neg);
      if (m > 64'sd4294967296) m = 64'sd4294967296;
      return neg ? -m : m;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = (absval(a) * absval(b)) >>> FRAC;
      return clamp(signed_mag(p, (a < 0) != (b < 0)));
    endfunction

    function longint qdiv(longint a, longint b);
      longint q;
      if (b == 0) begin
        flag(ST_DIV0);
        return a >= 0 ? 64'sd2147483647 : -64'sd2147483648;
      end
      q = (absval(a) << FRAC) / absval(b);
      return clamp(signed_mag(q, (a < 0) != (b < 0)));
    endfunction

    function longint qpow(longint a, longint b);
      longint acc, steps;
      acc = longint'(1) << FRAC;
      if (b <= 0) return acc;
      steps = (b + (longint'(1) << FRAC) - 1) >>> FRAC;
      if (steps > POW_MAX) steps = POW_MAX;
      for (longint i = 0; i < steps; i++) acc = qmul(acc, a);
      return acc;
    endfunction

    function void push(longint v);
      if (depth_used >= DEPTH) begin
        flag(ST_OVER);
        return;
      end
      stk[depth_used] = v[31:0];
      depth_used++;
    endfunction

    function void note_symbol(logic [7:0] sym, logic last);
      longint a, b, r;
      rpn_result_t res;
      if (sym >= ASCII_0 && sym <= ASCII_9) begin
        push(clamp(longint'(sym - ASCII_0) << FRAC));
      end else if (sym == ASCII_PLUS || sym == ASCII_MINUS || sym == ASCII_STAR ||
                   sym == ASCII_SLASH || sym == ASCII_CARET) begin
        if (depth_used < 2) begin
          flag(ST_UNDER);
        end else begin
          b = longint'(signed'(stk[depth_used-1]));
          a = longint'(signed'(stk[depth_used-2]));
          depth_used -= 2;
          case (sym)
            ASCII_PLUS:  r = clamp(a + b);
            ASCII_MINUS: r = clamp(a - b);
            ASCII_STAR:  r = qmul(a, b);
            ASCII_SLASH: r = qdiv(a, b);
            default:     r = qpow(a, b);
          endcase
          push(r);
        end
      end
      if (!last) return;
      res.value  = depth_used > 0 ? stk[depth_used-1] : 32'd0;
      res.status = err != ST_OK ? err : (depth_used == 0 ? ST_EMPTY : ST_OK);
      pending.push_back(res);
      clear_expr();
    endfunction

    task report_mismatch(string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_result(logic [31:0] value, logic [2:0] status);
      rpn_result_t exp_res;
      if (pending.size() == 0) begin
        report_mismatch("output beat with nothing expected");
        return;
      end
      exp_res = pending.pop_front();
      if (value !== exp_res.value)
        report_mismatch($sformatf("value %h, expected %h", value, exp_res.value));
      if (status !== exp_res.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, exp_res.status));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] symbol
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] value
  logic [2:0]  out_tuser;  // [2:0] status

  rpn_scoreboard rpn_sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_off;
  int            quiet_cycles;
  int            sent_chars;
  logic [7:0]    expr_chars[$];

  postfix_expression_evaluator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // accepted beats feed the scoreboard, sampled at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) rpn_sb.note_symbol(in_tdata, in_tlast);
      if (out_tvalid && out_tready) rpn_sb.check_result(out_tdata, out_tuser);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off   <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_off > 0)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // send one character, idling at random before it
  task automatic send_char(logic [7:0] sym, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_chars++;
  endtask

  task automatic send_expr(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_digit();
    return ASCII_0 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(4))
      0: return ASCII_PLUS;
      1: return ASCII_MINUS;
      2: return ASCII_STAR;
      3: return ASCII_SLASH;
      default: return ASCII_CARET;
    endcase
  endfunction

  // well-formed expression with random content and few powers, sometimes followed by one random byte
  task automatic send_random_expr();
    int need, len, live;
    logic [7:0] c;
    len  = $urandom_range(1, 7);
    live = 0;
    need = 0;
    while (need < len || live > 1) begin
      if (live >= 2 && (need >= len || $urandom_range(1))) begin
        c = pick_op();
        live--;
        if (c == ASCII_CARET && $urandom_range(3) != 0) c = ASCII_STAR;
      end else begin
        c = pick_digit();
        live++;
        need++;
      end
      expr_chars.push_back(c);
    end
    if ($urandom_range(9) == 0) expr_chars.push_back(8'($urandom_range(255)));
    while (expr_chars.size() > 0) begin
      c = expr_chars.pop_front();
      send_char(c, expr_chars.size() == 0);
    end
  endtask

  task automatic send_noise_expr();
    int len;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++)
      send_char(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic run_phase(int sender_pct, int receiver_pct, int n_chars);
    int base;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    base = sent_chars;
    while (sent_chars - base < n_chars) begin
      if ($urandom_range(9) < 8) send_random_expr();
      else send_noise_expr();
    end
  endtask

  initial begin
    string s;
    rpn_sb        = new();
    rpn_sb.clear_expr();
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = 8'd0;
    in_tlast      = 1'b0;
    hold_off      = 0;
    quiet_cycles  = 0;
    sent_chars    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operator, extremes and each error case
    send_expr("09+");
    send_expr("34-");
    send_expr("79*");
    send_expr("72/");
    send_expr("23^");
    send_expr("50^");
    send_expr("+");          // underflow
    send_expr("5/");         // underflow with one operand
    send_expr("90/");        // divide by zero, positive
    send_expr("09-0/");      // divide by zero, negative
    send_expr("x");          // empty stack
    send_send_depth: begin
      s = "";
      for (int i = 0; i < DEPTH + 1; i++) s = {s, "9"};
      send_expr(s);          // stack overflow
    end
    send_expr("99*9*9*9*");  // saturation high
    send_expr("09-99*9*9*9*9*");
    send_expr("29^9^");      // long power, saturates
    send_expr("09-9^");      // power of negative base
    send_expr("32-1-0^");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_expr("1 2+0/+");

    // long receiver hold-off while the sender keeps pushing
    hold_off = 3000;
    for (int i = 0; i < 12; i++) send_expr("12+");

    run_phase(32, 66, 90);
    run_phase(66, 32, 90);
    run_phase(0, 0, 90);

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (rpn_sb.pending.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (rpn_sb.fail_count == 0 && rpn_sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
